// ----- sv/mrnp_pkg.sv -----
`default_nettype none
package mrnp_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int RADIX_W  = 3;
    localparam int INDEX_W  = 8;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

    localparam logic [RADIX_W-1:0] RK_DEC  = 3'd0;
    localparam logic [RADIX_W-1:0] RK_HEX  = 3'd1;
    localparam logic [RADIX_W-1:0] RK_OCT  = 3'd2;
    localparam logic [RADIX_W-1:0] RK_BIN  = 3'd3;
    localparam logic [RADIX_W-1:0] RK_ZERO = 3'd4;

    localparam logic [VALUE_W-1:0] DEC_LIMIT = 32'd429496729;
    localparam logic [VALUE_W-1:0] HEX_TOP   = 32'hf000_0000;
    localparam logic [VALUE_W-1:0] OCT_TOP   = 32'he000_0000;
    localparam logic [VALUE_W-1:0] BIN_TOP   = 32'h8000_0000;

    typedef struct packed {
        logic [INDEX_W-1:0]  stop_index;
        logic [RADIX_W-1:0]  radix_kind;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] digit;
    } hex_digit_t;

    function automatic hex_digit_t hex_digit(input logic [CHAR_W-1:0] c);
        hex_digit_t d;
        d.valid = 1'b0;
        d.digit = 4'd0;
        if (c >= "0" && c <= "9") begin
            d.valid = 1'b1;
            d.digit = c[3:0];
        end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            d.valid = 1'b1;
            d.digit = c[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- sv/multi_radix_number_parser_unit.sv -----
// Streaming parser for one unsigned 32-bit number in ASCII text.
// Input beats: s_tdata carries one text byte, s_tuser marks the first byte
// of a new text (restarts the parse; that byte has offset 0).
// Output beats: one per parsed text, on the byte that ends the number:
// the value, a status (ok, no number, overflow), the radix kind and, for
// an ok status, the offset of the first byte not consumed. Bytes that do
// not end a parse produce no beat; bytes after the end are dropped until
// the next start. Throughput: one byte per cycle while no result is held.
// Each byte passes an input register and a single decode/shift-add step
// into the state and result registers; beats leave the result register.
// When m_tready is low the result is held; one more byte can be taken
// into the input register, then s_tready drops until the result leaves.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to idle, waiting for a byte with s_tuser set.
`default_nettype none
module multi_radix_number_parser_unit
    import mrnp_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] first
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // [31:0] value, [33:32] status,
                                        // [36:34] radix_kind, [44:37] stop_index
);

    localparam int CNT_W = $clog2(MAX_TEXT_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT_LEN);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SKIP = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;
    localparam logic [2:0] PH_OCT  = 3'd4;
    localparam logic [2:0] PH_BIN  = 3'd5;
    localparam logic [2:0] PH_DEC  = 3'd6;
    localparam logic [2:0] PH_DONE = 3'd7;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              first_reg;

    logic [2:0]         phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               seen_reg, seen_next;

    logic    out_valid_reg;
    result_t res_reg, res_next;

    logic               out_free, go, fire;
    logic [2:0]         phase_eff;
    logic [VALUE_W-1:0] acc_eff;
    logic [CNT_W-1:0]   cnt_eff;
    logic               seen_eff;
    logic [CNT_W+7:0]   cnt_ext;
    logic [INDEX_W-1:0] idx_sat;
    hex_digit_t         hd;
    logic [VALUE_W-1:0] acc_x10;

    assign out_free = !out_valid_reg || m_tready;
    assign go       = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            char_reg  <= s_tdata;
            first_reg <= s_tuser;
        end
    end

    always_comb begin
        phase_eff = first_reg ? PH_SKIP : phase_reg;
        acc_eff   = first_reg ? '0 : acc_reg;
        cnt_eff   = first_reg ? '0 : cnt_reg;
        seen_eff  = first_reg ? 1'b0 : seen_reg;
        cnt_ext   = {8'd0, cnt_eff};
        idx_sat   = (cnt_ext > (CNT_W+8)'(255)) ? 8'd255 : cnt_ext[7:0];
        hd        = hex_digit(char_reg);
        acc_x10   = (acc_eff << 3) + (acc_eff << 1);

        phase_next = phase_eff;
        acc_next   = acc_eff;
        seen_next  = seen_eff;
        cnt_next   = (cnt_eff < CNT_MAX) ? cnt_eff + CNT_W'(1) : cnt_eff;
        fire       = 1'b0;
        res_next.value      = '0;
        res_next.status     = ST_NONE;
        res_next.radix_kind = RK_DEC;
        res_next.stop_index = '0;

        unique case (phase_eff)
            PH_SKIP: begin
                if (char_reg == 8'd0) begin
                    fire = 1'b1;
                end else if (char_reg <= " ") begin
                end else if (char_reg == "0") begin
                    phase_next = PH_ZERO;
                end else if (char_reg == "b" || char_reg == "B") begin
                    phase_next = PH_BIN;
                    acc_next   = '0;
                    seen_next  = 1'b0;
                end else if (char_reg >= "1" && char_reg <= "9") begin
                    phase_next = PH_DEC;
                    acc_next   = {28'd0, char_reg[3:0]};
                end else begin
                    fire = 1'b1;
                end
            end
            PH_ZERO: begin
                if (char_reg == "x" || char_reg == "X") begin
                    phase_next = PH_HEX;
                    acc_next   = '0;
                    seen_next  = 1'b0;
                end else if (char_reg >= "0" && char_reg <= "7") begin
                    phase_next = PH_OCT;
                    acc_next   = {29'd0, char_reg[2:0]};
                end else begin
                    fire = 1'b1;
                    res_next.status     = ST_OK;
                    res_next.radix_kind = RK_ZERO;
                    res_next.stop_index = idx_sat;
                end
            end
            PH_HEX: begin
                res_next.radix_kind = RK_HEX;
                if (!hd.valid) begin
                    fire = 1'b1;
                    if (seen_eff) begin
                        res_next.status     = ST_OK;
                        res_next.value      = acc_eff;
                        res_next.stop_index = idx_sat;
                    end
                end else if ((acc_eff & HEX_TOP) != '0) begin
                    fire = 1'b1;
                    res_next.status = ST_OVF;
                end else begin
                    acc_next  = {acc_eff[27:0], hd.digit};
                    seen_next = 1'b1;
                end
            end
            PH_OCT: begin
                res_next.radix_kind = RK_OCT;
                if (char_reg < "0" || char_reg > "7") begin
                    fire = 1'b1;
                    res_next.status     = ST_OK;
                    res_next.value      = acc_eff;
                    res_next.stop_index = idx_sat;
                end else if ((acc_eff & OCT_TOP) != '0) begin
                    fire = 1'b1;
                    res_next.status = ST_OVF;
                end else begin
                    acc_next = {acc_eff[28:0], char_reg[2:0]};
                end
            end
            PH_BIN: begin
                res_next.radix_kind = RK_BIN;
                if (char_reg != "0" && char_reg != "1") begin
                    fire = 1'b1;
                    if (seen_eff) begin
                        res_next.status     = ST_OK;
                        res_next.value      = acc_eff;
                        res_next.stop_index = idx_sat;
                    end
                end else if ((acc_eff & BIN_TOP) != '0) begin
                    fire = 1'b1;
                    res_next.status = ST_OVF;
                end else begin
                    acc_next  = {acc_eff[30:0], char_reg[0]};
                    seen_next = 1'b1;
                end
            end
            PH_DEC: begin
                if (char_reg < "0" || char_reg > "9") begin
                    fire = 1'b1;
                    res_next.status     = ST_OK;
                    res_next.value      = acc_eff;
                    res_next.stop_index = idx_sat;
                end else if (acc_eff > DEC_LIMIT ||
                             (acc_eff == DEC_LIMIT && char_reg > "5")) begin
                    fire = 1'b1;
                    res_next.status = ST_OVF;
                end else begin
                    acc_next = acc_x10 + {28'd0, char_reg[3:0]};
                end
            end
            default: begin
                // idle or done: drop the byte
                phase_next = phase_eff;
                cnt_next   = cnt_eff;
            end
        endcase

        if (fire) begin
            phase_next = PH_DONE;
            cnt_next   = cnt_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (go) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                seen_reg  <= seen_next;
            end
            if (go && fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (go && fire) begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

// ----- sim/number_parse_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module number_parse_checker
    import mrnp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] first
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // [31:0] value, [33:32] status,
                                        // [36:34] radix_kind, [44:37] stop_index
    output int               mismatch_count,
    output int               numbers_outstanding
);

    typedef enum logic [3:0] {
        P_IDLE, P_SKIP, P_ZERO, P_HEX, P_OCT, P_BIN, P_DEC, P_DONE
    } phase_e;

    phase_e             phase;
    logic [VALUE_W-1:0] acc;
    logic [INDEX_W-1:0] offset;
    logic               seen;
    result_t            expected_numbers[$];

    initial begin
        mismatch_count      = 0;
        numbers_outstanding = 0;
        phase               = P_IDLE;
        acc                 = '0;
        offset              = '0;
        seen                = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    task automatic end_number(input logic [STATUS_W-1:0] status,
                              input logic [RADIX_W-1:0] radix,
                              input logic [VALUE_W-1:0] val);
        result_t r;
        r.status     = status;
        r.radix_kind = radix;
        r.value      = (status == ST_OK) ? val : '0;
        r.stop_index = (status == ST_OK) ? offset : '0;
        expected_numbers.push_back(r);
        phase = P_DONE;
    endtask

    task automatic parse_byte(input logic [7:0] c, input logic first);
        int d;
        if (first) begin
            phase  = P_SKIP;
            acc    = '0;
            offset = '0;
            seen   = 1'b0;
        end
        if (phase != P_IDLE && phase != P_DONE) begin
            case (phase)
                P_SKIP: begin
                    if (c == 8'd0)
                        end_number(ST_NONE, RK_DEC, '0);
                    else if (c <= 8'd32)
                        ;
                    else if (c == "0")
                        phase = P_ZERO;
                    else if (c == "b" || c == "B") begin
                        phase = P_BIN;
                        acc   = '0;
                        seen  = 1'b0;
                    end else if (c >= "1" && c <= "9") begin
                        phase = P_DEC;
                        acc   = VALUE_W'(c - "0");
                    end else
                        end_number(ST_NONE, RK_DEC, '0);
                end
                P_ZERO: begin
                    if (c == "x" || c == "X") begin
                        phase = P_HEX;
                        acc   = '0;
                        seen  = 1'b0;
                    end else if (c >= "0" && c <= "7") begin
                        phase = P_OCT;
                        acc   = VALUE_W'(c - "0");
                    end else
                        end_number(ST_OK, RK_ZERO, '0);
                end
                P_HEX: begin
                    d = hex_value(c);
                    if (d < 0) begin
                        if (seen) end_number(ST_OK, RK_HEX, acc);
                        else      end_number(ST_NONE, RK_HEX, '0);
                    end else if ((acc & HEX_TOP) != 0)
                        end_number(ST_OVF, RK_HEX, '0);
                    else begin
                        acc  = (acc << 4) + VALUE_W'(d);
                        seen = 1'b1;
                    end
                end
                P_OCT: begin
                    if (c < "0" || c > "7")
                        end_number(ST_OK, RK_OCT, acc);
                    else if ((acc & OCT_TOP) != 0)
                        end_number(ST_OVF, RK_OCT, '0);
                    else
                        acc = (acc << 3) + VALUE_W'(c - "0");
                end
                P_BIN: begin
                    if (c != "0" && c != "1") begin
                        if (seen) end_number(ST_OK, RK_BIN, acc);
                        else      end_number(ST_NONE, RK_BIN, '0);
                    end else if ((acc & BIN_TOP) != 0)
                        end_number(ST_OVF, RK_BIN, '0);
                    else begin
                        acc  = (acc << 1) | VALUE_W'(c - "0");
                        seen = 1'b1;
                    end
                end
                default: begin
                    if (c < "0" || c > "9")
                        end_number(ST_OK, RK_DEC, acc);
                    else if (acc > DEC_LIMIT || (acc == DEC_LIMIT && c > "5"))
                        end_number(ST_OVF, RK_DEC, '0);
                    else
                        acc = VALUE_W'(acc * 10) + VALUE_W'(c - "0");
                end
            endcase
            if (phase != P_DONE && offset < 8'd255)
                offset++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            phase  = P_IDLE;
            acc    = '0;
            offset = '0;
            seen   = 1'b0;
            expected_numbers.delete();
        end else begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_numbers.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat %h", m_tdata));
                end else begin
                    got  = result_t'(m_tdata[44:0]);
                    want = expected_numbers.pop_front();
                    if (got.value !== want.value)
                        report_mismatch($sformatf("value %h, want %h",
                                                  got.value, want.value));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    if (got.radix_kind !== want.radix_kind)
                        report_mismatch($sformatf("radix_kind %0d, want %0d",
                                                  got.radix_kind, want.radix_kind));
                    if (got.stop_index !== want.stop_index)
                        report_mismatch($sformatf("stop_index %0d, want %0d",
                                                  got.stop_index, want.stop_index));
                    if (m_tdata[47:45] !== 3'd0)
                        report_mismatch($sformatf("tdata padding %b", m_tdata[47:45]));
                end
            end
        end
        numbers_outstanding <= expected_numbers.size();
    end

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import mrnp_pkg::*;

    typedef enum int {
        TXT_DEC, TXT_HEX, TXT_OCT, TXT_BIN, TXT_ZERO, TXT_NOISE, TXT_EDGE
    } text_kind_e;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_code
    logic        s_tuser;   // [0] first
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [31:0] value, [33:32] status,
                            // [36:34] radix_kind, [44:37] stop_index
    int          mismatch_count;
    int          numbers_outstanding;

    logic [7:0]  text_q[$];
    int          items_sent;
    bit          sender_burst;
    bit          receiver_burst;

    multi_radix_number_parser_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    number_parse_checker checker_i (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .mismatch_count      (mismatch_count),
        .numbers_outstanding (numbers_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int stall;
        m_tready       <= 1'b0;
        receiver_burst = 1'b0;
        forever begin
            if ($urandom_range(0, 15) == 0)
                receiver_burst = !receiver_burst;
            stall = receiver_burst ? 0 : $urandom_range(0, 5);
            repeat (stall) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1));
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic first);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= first;
        do @(posedge aclk); while (!(s_tready === 1'b1));
    endtask

    task automatic push_byte(input logic [7:0] b);
        text_q.push_back(b);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == 0);
            items_sent++;
        end
        text_q.delete();
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (numbers_outstanding != 0) @(posedge aclk);
    endtask

    function automatic bit continues(input text_kind_e kind, input logic [7:0] c);
        case (kind)
            TXT_HEX:  return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                             (c >= "A" && c <= "F");
            TXT_OCT:  return c >= "0" && c <= "7";
            TXT_BIN:  return c == "0" || c == "1";
            TXT_ZERO: return c == "x" || c == "X" || (c >= "0" && c <= "7");
            default:  return c >= "0" && c <= "9";
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input int d);
        if (d < 10) return 8'("0" + d);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
    endfunction

    task automatic build_random_text();
        text_kind_e kind;
        int         n;
        logic [7:0] c;
        case ($urandom_range(0, 10))
            0, 1:    kind = TXT_DEC;
            2, 3:    kind = TXT_HEX;
            4:       kind = TXT_OCT;
            5, 6:    kind = TXT_BIN;
            7:       kind = TXT_ZERO;
            8:       kind = TXT_NOISE;
            default: kind = TXT_EDGE;
        endcase
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(1, 32)));
        case (kind)
            TXT_DEC: begin
                push_byte(8'($urandom_range("1", "9")));
                repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range("0", "9")));
            end
            TXT_HEX: begin
                push_byte("0");
                push_byte($urandom_range(0, 1) ? "x" : "X");
                repeat ($urandom_range(0, 9)) push_byte(hex_char($urandom_range(0, 15)));
            end
            TXT_OCT: begin
                push_byte("0");
                repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range("0", "7")));
            end
            TXT_BIN: begin
                push_byte($urandom_range(0, 1) ? "b" : "B");
                n = $urandom_range(0, 34);
                repeat (n) push_byte(8'($urandom_range("0", "1")));
            end
            TXT_ZERO:
                push_byte("0");
            TXT_NOISE:
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            default: begin
                push_str("429496729");
                push_byte(8'($urandom_range("0", "9")));
            end
        endcase
        if (kind != TXT_NOISE && $urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 3) == 0)
                c = 8'd0;
            else
                do c = 8'($urandom_range(0, 255)); while (continues(kind, c));
            push_byte(c);
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= 8'd0;
        s_tuser      <= 1'b0;
        items_sent   = 0;
        sender_burst = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // bytes before any start
        send_byte("5", 1'b0);
        send_byte(8'd0, 1'b0);

        push_str("4294967295 ");   send_text();
        push_str("4294967296");    send_text();
        push_str("42949672950");   send_text();
        push_byte(8'd9); push_str("  0xFFFFFFFF;"); send_text();
        push_str("0X100000000");   send_text();
        push_str("037777777777 "); send_text();
        push_str("040000000000");  send_text();
        push_byte("b"); repeat (32) push_byte("1"); push_byte("2"); send_text();
        push_byte("B"); repeat (33) push_byte("1"); send_text();
        push_str("0xg");           send_text();
        push_str("0x"); push_byte(8'd0); send_text();
        push_str("b"); push_byte(8'd0);  send_text();
        push_str("0"); push_byte(8'd0);  send_text();
        push_str("09");            send_text();
        push_str("0 ");            send_text();
        push_byte(8'd0);           send_text();
        push_byte(8'd1); push_byte(8'd32); push_byte(8'd31); push_byte(8'd0);
        send_text();
        push_str("abc");           send_text();
        push_byte(8'd255);         send_text();
        push_byte(8'd128);         send_text();
        push_str("0xaBcDeF12 ");   send_text();
        // restart in the middle of a number, then drop bytes after the end
        push_str("12");            send_text();
        push_str("7"); push_byte(8'd0); send_text();
        send_byte("9", 1'b0);
        send_byte("9", 1'b0);
        repeat (260) push_byte(8'd32);
        push_str("7 ");            send_text();
        push_byte("0"); repeat (300) push_byte("0"); push_byte("8"); send_text();

        hold_until_drained();

        while (items_sent < 1850) begin
            sender_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 24) == 0)
                hold_until_drained();
            build_random_text();
            send_text();
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        for (int guard = 0; guard < 5000 && numbers_outstanding != 0; guard++)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0 && numbers_outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
